### hw/rtl/rm_pkg.sv
// ----------------------------------------------------------------------------
// Running median package
// Shared widths, constants and elaboration helpers for the running median.
// ----------------------------------------------------------------------------
package rm_pkg;

  // Fixed payload widths of the transfer channels.
  localparam int SAMPLE_PORT_BITS = 32;
  localparam int MEDIAN_BITS      = 33;
  localparam int COUNT_BITS       = 9;

  // Fan-in of each node of the registered selection tree.
  localparam int TREE_RADIX      = 4;
  localparam int TREE_RADIX_LOG2 = $clog2(TREE_RADIX);

  // Number of registered tree levels needed to reduce n leaves to one node.
  function automatic int tree_levels(input int n);
    int levels;
    int span;
    levels = 1;
    span   = TREE_RADIX;
    while (span < n) begin
      span   = span * TREE_RADIX;
      levels = levels + 1;
    end
    return levels;
  endfunction

  // Leaf count after padding to a full tree.
  function automatic int tree_leaves(input int n);
    return TREE_RADIX ** tree_levels(n);
  endfunction

  // Number of nodes on tree level lvl (level 0 is fed by the leaves).
  function automatic int tree_nodes(input int leaves, input int lvl);
    return leaves >> (TREE_RADIX_LOG2 * (lvl + 1));
  endfunction

  // Position of the first node of level lvl in the flattened node array.
  function automatic int tree_offset(input int leaves, input int lvl);
    int off;
    off = 0;
    for (int m = 0; m < lvl; m++) begin
      off = off + tree_nodes(leaves, m);
    end
    return off;
  endfunction

endpackage

### hw/rtl/rm_in_if.sv
// ----------------------------------------------------------------------------
// Running median sample channel
// Valid/ready channel that carries one signed sample per transfer.
// ----------------------------------------------------------------------------
interface rm_in_if;

  logic                                       valid;
  logic                                       ready;
  logic signed [rm_pkg::SAMPLE_PORT_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

### hw/rtl/rm_out_if.sv
// ----------------------------------------------------------------------------
// Running median result channel
// Valid/ready channel that carries one median result per transfer.
// ----------------------------------------------------------------------------
interface rm_out_if;

  logic                                  valid;
  logic                                  ready;
  logic signed [rm_pkg::MEDIAN_BITS-1:0] median_twice;
  logic        [rm_pkg::COUNT_BITS-1:0]  stored_count;
  logic                                  overflow;

  modport source (output valid, output median_twice, output stored_count,
                  output overflow, input ready);
  modport sink   (input valid, input median_twice, input stored_count,
                  input overflow, output ready);

endinterface

### hw/rtl/rm_cell.sv
// ----------------------------------------------------------------------------
// Running median store cell
// One entry of the sorted store with its insert compare and median tap.
// ----------------------------------------------------------------------------
module rm_cell #(
  parameter int SB    = 32,
  parameter int CW    = 9,
  parameter int IW    = 8,
  parameter int INDEX = 0
) (
  input  logic                 clk_i,
  input  logic                 ins_en_i,
  input  logic signed [SB-1:0] sample_i,
  input  logic        [CW-1:0] fill_i,
  input  logic        [IW-1:0] lo_idx_i,
  input  logic        [IW-1:0] hi_idx_i,
  input  logic signed [SB-1:0] left_val_i,
  input  logic                 left_ins_i,
  output logic signed [SB-1:0] val_o,
  output logic                 ins_o,
  output logic        [SB-1:0] lo_o,
  output logic        [SB-1:0] hi_o
);

  logic signed [SB-1:0] val_q, val_d;
  logic                 used;

  // An empty entry, or one greater than the sample, lies at or after the
  // insert point, so equal entries stay in front of the new sample.
  assign used  = CW'(INDEX) < fill_i;
  assign ins_o = !used || (val_q > sample_i);

  always_comb begin
    val_d = val_q;
    if (ins_en_i && ins_o) begin
      val_d = left_ins_i ? left_val_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign lo_o  = (IW'(INDEX) == lo_idx_i) ? val_q : '0;
  assign hi_o  = (IW'(INDEX) == hi_idx_i) ? val_q : '0;

endmodule

### hw/rtl/rm_or_tree.sv
// ----------------------------------------------------------------------------
// Running median selection tree
// Registered OR tree that gathers the one nonzero tap of the cell row.
// ----------------------------------------------------------------------------
module rm_or_tree #(
  parameter int W = 64,
  parameter int N = 256
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);

  import rm_pkg::*;

  localparam int LEVELS = tree_levels(N);
  localparam int LEAVES = tree_leaves(N);
  localparam int TOTAL  = (LEAVES - 1) / (TREE_RADIX - 1);

  logic [W-1:0] pad   [LEAVES];
  logic [W-1:0] node_q[TOTAL];

  for (genvar k = 0; k < LEAVES; k++) begin : g_pad
    if (k < N) begin : g_real
      assign pad[k] = leaf_i[k];
    end else begin : g_zero
      assign pad[k] = '0;
    end
  end

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int OFF  = tree_offset(LEAVES, l);
    localparam int NODE = tree_nodes(LEAVES, l);
    for (genvar j = 0; j < NODE; j++) begin : g_node
      logic [W-1:0] sum;
      if (l == 0) begin : g_first
        always_comb begin
          sum = '0;
          for (int c = 0; c < TREE_RADIX; c++) begin
            sum = sum | pad[TREE_RADIX*j + c];
          end
        end
      end else begin : g_upper
        localparam int POFF = tree_offset(LEAVES, l - 1);
        always_comb begin
          sum = '0;
          for (int c = 0; c < TREE_RADIX; c++) begin
            sum = sum | node_q[POFF + TREE_RADIX*j + c];
          end
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          node_q[OFF + j] <= sum;
        end
      end
    end
  end

  assign root_o = node_q[TOTAL-1];

endmodule

### hw/rtl/running_median.sv
// ----------------------------------------------------------------------------
// Running median
// Sorted sample store built as a row of insert cells, with a registered tree
// that picks the two middle entries and an adder that reports twice the median.
// ----------------------------------------------------------------------------
// Path: a transfer updates the cell row, then passes the tree_levels(CAPACITY)
//   registered levels of the 4-ary tree and the output register.
// Throughput: one sample per cycle while no held result stalls the pipeline.
// Reset: rst_ni clears the fill count and all pipeline valid flags; stored
//   entries are not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module running_median #(
  parameter int CAPACITY    = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rm_in_if.sink   in_i,
  rm_out_if.source out_o
);

  import rm_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int IW     = $clog2(CAPACITY);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int RW     = (SB > SAMPLE_PORT_BITS) ? SB : SAMPLE_PORT_BITS;
  localparam int MW     = (SB + 1 > MEDIAN_BITS) ? SB + 1 : MEDIAN_BITS;

  // --------------------------------------------------------------------------
  // Pipeline enable. Every stage moves together whenever the output register
  // is empty or its result is being taken, so a new sample is accepted in the
  // same cycle that an older result leaves.
  // --------------------------------------------------------------------------
  logic en;
  logic in_xfer;
  logic out_valid_q;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign in_xfer     = in_i.valid && en;

  // Only the low SAMPLE_BITS bits of the input count; they are taken as a
  // signed value.
  logic [RW-1:0]        raw;
  logic signed [SB-1:0] sample;

  assign raw    = RW'($unsigned(in_i.sample));
  assign sample = signed'(raw[SB-1:0]);

  // --------------------------------------------------------------------------
  // Fill count. Once the store is full a sample is dropped and flagged.
  // --------------------------------------------------------------------------
  logic [CW-1:0] fill_q, fill_d;
  logic          full;
  logic          ins_en;

  assign full   = fill_q == CW'(CAPACITY);
  assign ins_en = in_xfer && !full;
  assign fill_d = ins_en ? fill_q + CW'(1) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Middle positions of the current store: for an odd count both point at
  // the center entry, for an even count they are the two central entries.
  logic [CW-1:0] lo_full;
  logic [IW-1:0] lo_idx, hi_idx;

  assign lo_full = (fill_q - CW'(1)) >> 1;
  assign lo_idx  = lo_full[IW-1:0];
  assign hi_idx  = IW'(fill_q >> 1);

  // --------------------------------------------------------------------------
  // Cell row. Each cell compares its entry against the sample; cells at or
  // past the insert point take the entry of their left neighbor, and the
  // first of them takes the sample, which shifts the tail up by one.
  // --------------------------------------------------------------------------
  logic signed [SB-1:0] cell_val[CAPACITY];
  logic                 cell_ins[CAPACITY];
  logic [2*SB-1:0]      leaf    [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [SB-1:0] left_val;
    logic                 left_ins;
    logic [SB-1:0]        lo_tap, hi_tap;

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_ins = 1'b0;
    end else begin : g_link
      assign left_val = cell_val[i-1];
      assign left_ins = cell_ins[i-1];
    end

    rm_cell #(
      .SB    (SB),
      .CW    (CW),
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ins_en_i   (ins_en),
      .sample_i   (sample),
      .fill_i     (fill_q),
      .lo_idx_i   (lo_idx),
      .hi_idx_i   (hi_idx),
      .left_val_i (left_val),
      .left_ins_i (left_ins),
      .val_o      (cell_val[i]),
      .ins_o      (cell_ins[i]),
      .lo_o       (lo_tap),
      .hi_o       (hi_tap)
    );

    assign leaf[i] = {hi_tap, lo_tap};
  end

  // --------------------------------------------------------------------------
  // Selection tree. The row holds the new store in the cycle after the
  // transfer; the tree samples the tapped middle entries when the pipeline
  // moves on and narrows them down over LEVELS registered levels.
  // --------------------------------------------------------------------------
  logic [2*SB-1:0] root;

  rm_or_tree #(
    .W (2*SB),
    .N (CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .en_i   (en),
    .leaf_i (leaf),
    .root_o (root)
  );

  // Side pipeline that keeps the valid flag, count and overflow flag of each
  // item aligned with its tree level. Stage zero matches the cell row.
  logic                  side_vld_q[LEVELS+1];
  logic [COUNT_BITS-1:0] side_cnt_q[LEVELS+1];
  logic                  side_ovf_q[LEVELS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LEVELS; k++) begin
        side_vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      side_vld_q[0] <= in_xfer;
      for (int k = 1; k <= LEVELS; k++) begin
        side_vld_q[k] <= side_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_cnt_q[0] <= COUNT_BITS'(fill_d);
      side_ovf_q[0] <= full;
      for (int k = 1; k <= LEVELS; k++) begin
        side_cnt_q[k] <= side_cnt_q[k-1];
        side_ovf_q[k] <= side_ovf_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register. Twice the median is the plain sum of the two middle
  // entries, which is exact for SAMPLE_BITS up to 32 and needs no rounding.
  // --------------------------------------------------------------------------
  logic signed [SB-1:0]          lo_val, hi_val;
  logic signed [MW-1:0]          med_sum;
  logic signed [MEDIAN_BITS-1:0] median_q;
  logic [COUNT_BITS-1:0]         count_q;
  logic                          ovf_q;

  assign lo_val  = signed'(root[SB-1:0]);
  assign hi_val  = signed'(root[2*SB-1:SB]);
  assign med_sum = MW'(lo_val) + MW'(hi_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_vld_q[LEVELS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      median_q <= signed'(med_sum[MEDIAN_BITS-1:0]);
      count_q  <= side_cnt_q[LEVELS];
      ovf_q    <= side_ovf_q[LEVELS];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.median_twice = median_q;
  assign out_o.stored_count = count_q;
  assign out_o.overflow     = ovf_q;

endmodule

### hw/rtl/rm_checker.sv
// ----------------------------------------------------------------------------
// Running median port checker
// Concurrent assertions on the ports of the running median, bound to its top.
// ----------------------------------------------------------------------------
module rm_checker #(
  parameter int CAPACITY = 256
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_i,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic signed [rm_pkg::MEDIAN_BITS-1:0] median_twice_i,
  input logic        [rm_pkg::COUNT_BITS-1:0]  stored_count_i,
  input logic                                  overflow_i
);

  import rm_pkg::*;

  // Number of samples accepted whose results have not yet been transferred.
  logic [4:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 5'(in_xfer) - 5'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(median_twice_i) && $stable(stored_count_i) && $stable(overflow_i))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result shown without an accepted sample");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> stored_count_i != '0)
    else $error("result reports an empty store");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i |-> stored_count_i == COUNT_BITS'(CAPACITY))
    else $error("overflow flagged while the store is not full");

endmodule

bind running_median rm_checker #(
  .CAPACITY (CAPACITY)
) u_rm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .median_twice_i (out_o.median_twice),
  .stored_count_i (out_o.stored_count),
  .overflow_i     (out_o.overflow)
);
